@@ rtl/msgid_pkg.sv @@
`default_nettype none

package msgid_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned CODE_W  = 3;

    localparam logic [LEN_W-1:0] COUNT_MAX   = 10'd1023;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 10'd250;

    // verdict codes
    localparam logic [CODE_W-1:0] ERR_OK        = 3'd0;
    localparam logic [CODE_W-1:0] ERR_NO_OPEN   = 3'd1;
    localparam logic [CODE_W-1:0] ERR_BAD_CHAR  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_NO_CLOSE  = 3'd3;
    localparam logic [CODE_W-1:0] ERR_TRAIL_DOT = 3'd4;
    localparam logic [CODE_W-1:0] ERR_TOO_LONG  = 3'd5;
    localparam logic [CODE_W-1:0] ERR_GARBAGE   = 3'd6;

    // byte constants
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_BODY,
        PH_AFTER,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last;
    } msgid_in_t;

    typedef struct packed {
        logic              valid_res;
        logic [CODE_W-1:0] error_code;
        logic [LEN_W-1:0]  start_offset;
        logic [LEN_W-1:0]  id_length;
    } msgid_out_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

@@ rtl/message_id_validator.sv @@
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------
// s_        | in        | s_valid / s_ready    | msgid_in_t : char_in, last
// m_        | out       | m_valid / m_ready    | msgid_out_t: valid_res, error_code,
//           |           |                      |              start_offset, id_length
// cfg_      | in        | cfg_valid/cfg_ready  | cfg_max_len (10 bits)
//
// Cycles: one byte beat per cycle while s_ready is high; a verdict appears on m_
//   in the cycle after the deciding beat is taken. The per-string scanner state and
//   the result register are the only pipeline stages.
// Reset: synchronous, active low; max_len returns to 250 and the scanner to
//   the leading-whitespace phase at offset zero.
// Stalls: s_ready drops only while a verdict sits in the result register and
//   m_ready is low; beats that give no verdict still need that slot free.
module message_id_validator #(
    parameter int LINE_BYTES = 1024
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  msgid_pkg::msgid_in_t          s_payload,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output msgid_pkg::msgid_out_t               m_payload,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [msgid_pkg::LEN_W-1:0]         cfg_max_len
);
    import msgid_pkg::*;

    // saturation point of the byte position
    localparam logic [LEN_W-1:0] POS_MAX =
        LEN_W'((LINE_BYTES - 1 < 1023) ? LINE_BYTES - 1 : 1023);

    logic [LEN_W-1:0] max_len_reg;

    phase_t           phase_reg,   phase_next;
    logic [LEN_W-1:0] pos_reg,     pos_next;
    logic [LEN_W-1:0] start_reg,   start_next;
    logic [LEN_W-1:0] count_reg,   count_next;
    logic             dot_reg,     dot_next;

    logic             m_valid_reg;
    msgid_out_t       result_reg,  result_next;
    logic             emit;

    logic             s_accept;
    logic [LEN_W-1:0] pos_inc;
    logic [LEN_W-1:0] count_inc;
    logic [CHAR_W-1:0] c;
    logic             fin;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

    assign c         = s_payload.char_in;
    assign fin       = s_payload.last;
    assign pos_inc   = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    // Scanner: decide the next state and whether this beat gives the verdict.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_inc;
        start_next  = start_reg;
        count_next  = count_reg;
        dot_next    = dot_reg;
        emit        = 1'b0;
        result_next = '{valid_res: 1'b0, error_code: ERR_OK,
                        start_offset: start_reg, id_length: count_reg};

        unique case (phase_reg)
            PH_SKIP: begin
                if (c != CH_NUL && is_space(c)) begin
                    // all whitespace: report the end of the string
                    if (fin) begin
                        emit = 1'b1;
                        result_next.error_code   = ERR_NO_OPEN;
                        result_next.start_offset = pos_inc;
                        result_next.id_length    = '0;
                    end
                end else if (c == CH_LT) begin
                    start_next = pos_reg;
                    count_next = 10'd1;
                    dot_next   = 1'b0;
                    phase_next = PH_BODY;
                    if (fin) begin
                        emit = 1'b1;
                        result_next.error_code   = ERR_NO_CLOSE;
                        result_next.start_offset = pos_reg;
                        result_next.id_length    = 10'd1;
                    end
                end else begin
                    emit = 1'b1;
                    result_next.error_code   = ERR_NO_OPEN;
                    result_next.start_offset = pos_reg;
                    result_next.id_length    = '0;
                end
            end
            PH_BODY: begin
                count_next            = count_inc;
                result_next.id_length = count_inc;
                if (c == CH_NUL) begin
                    emit = 1'b1;
                    result_next.error_code = ERR_NO_CLOSE;
                end else if (c == CH_GT) begin
                    // dot check wins over length, length over what follows
                    if (count_inc > 10'd3 && dot_reg) begin
                        emit = 1'b1;
                        result_next.error_code = ERR_TRAIL_DOT;
                    end else if (count_inc >= max_len_reg) begin
                        emit = 1'b1;
                        result_next.error_code = ERR_TOO_LONG;
                    end else if (fin) begin
                        emit = 1'b1;
                        result_next.error_code = ERR_OK;
                    end else begin
                        phase_next = PH_AFTER;
                    end
                end else if (c == CH_LT || is_space(c)) begin
                    emit = 1'b1;
                    result_next.error_code = ERR_BAD_CHAR;
                end else begin
                    dot_next = (c == CH_DOT);
                    if (fin) begin
                        emit = 1'b1;
                        result_next.error_code = ERR_NO_CLOSE;
                    end
                end
            end
            PH_AFTER: begin
                emit = 1'b1;
                result_next.error_code =
                    (c == CH_NUL || is_space(c)) ? ERR_OK : ERR_GARBAGE;
            end
            PH_DONE: begin
                // drop the rest of the string
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        result_next.valid_res = (result_next.error_code == ERR_OK);

        if (emit) begin
            phase_next = PH_DONE;
        end

        // last beat always restarts the scanner
        if (fin) begin
            phase_next = PH_SKIP;
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
            dot_next   = 1'b0;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_max_len;
        end
    end

    // Scanner state: advance on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            dot_reg   <= 1'b0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            dot_reg   <= dot_next;
        end
    end

    // Result register: load on a deciding beat, hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            result_reg <= result_next;
        end
    end

    // A verdict only appears after a beat was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted beat");

    // valid_res and the ok code agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.valid_res == (m_payload.error_code == ERR_OK)))
        else $error("valid_res disagrees with error_code");

    // After a last beat the scanner is back at the start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_payload.last) |=> (phase_reg == PH_SKIP && pos_reg == '0))
        else $error("scanner not cleared after last beat");

    // Once decided, the string gives nothing more until its last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_DONE && !s_payload.last)
            |=> (phase_reg == PH_DONE && !$rose(m_valid)))
        else $error("second verdict within one string");

    // Position stays within its saturation bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("position exceeded its bound");

endmodule

`default_nettype wire

@@ verif/message_id_validator_test.sv @@
`timescale 1ns / 100ps

module message_id_validator_test;

    import msgid_pkg::*;

    localparam int LINE_BYTES = 1024;
    // Offset counter saturates at the smaller of the last line offset and the field limit
    localparam logic [LEN_W-1:0] POS_CAP =
        (LINE_BYTES - 1 < 1023) ? LEN_W'(LINE_BYTES - 1) : LEN_W'(1023);
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    msgid_in_t  s_payload = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    msgid_out_t m_payload;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_max_len = '0;

    // Stimulus and expectation stores
    msgid_in_t        beat_q[$];      // bytes waiting for the driver
    msgid_out_t       verdict_q[$];   // verdicts the block still owes us
    logic [CHAR_W-1:0] str_buf[$];    // string under construction

    int  beats_queued = 0;
    int  beats_taken = 0;
    int  miss_count = 0;
    bit  gaps_on = 1'b1;
    bit  hold_rx = 1'b0;

    // Scanner shadow state
    phase_t           scan_ph = PH_SKIP;
    logic [LEN_W-1:0] scan_pos = '0;
    logic [LEN_W-1:0] open_at = '0;
    logic [LEN_W-1:0] span = '0;
    logic             dot_seen = 1'b0;
    logic [LEN_W-1:0] id_limit = MAX_LEN_RST;

    message_id_validator #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_max_len (cfg_max_len)
    );

    // 20 ns period: high half, low half
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Hold reset from the start, release once, never again
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow scanner: mirrors the validator's decision on each taken byte
    // ------------------------------------------------------------------
    function automatic bit blank(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    task automatic record_verdict(input logic [CODE_W-1:0] code,
                                  input logic [LEN_W-1:0] start,
                                  input logic [LEN_W-1:0] len);
        msgid_out_t v;
        v.valid_res    = (code == ERR_OK);
        v.error_code   = code;
        v.start_offset = start;
        v.id_length    = len;
        verdict_q.push_back(v);
        scan_ph = PH_DONE;
    endtask

    task automatic scan_byte(input msgid_in_t b);
        logic [CHAR_W-1:0] c;
        logic [LEN_W-1:0]  here;
        c = b.char_in;
        here = scan_pos;
        if (scan_pos < POS_CAP) scan_pos = scan_pos + 1'b1;

        case (scan_ph)
            PH_SKIP: begin
                if (blank(c)) begin
                    // all-blank string reports the end position
                    if (b.last) record_verdict(ERR_NO_OPEN, scan_pos, '0);
                end else if (c == CH_LT) begin
                    open_at = here;
                    span = LEN_W'(1);
                    dot_seen = 1'b0;
                    scan_ph = PH_BODY;
                    if (b.last) record_verdict(ERR_NO_CLOSE, open_at, span);
                end else begin
                    // NUL lands here too: it ends the string before any '<'
                    record_verdict(ERR_NO_OPEN, here, '0);
                end
            end
            PH_BODY: begin
                if (span < COUNT_MAX) span = span + 1'b1;
                if (c == CH_NUL) begin
                    record_verdict(ERR_NO_CLOSE, open_at, span);
                end else if (c == CH_GT) begin
                    // trailing dot beats length; length beats whatever follows
                    if (span > 3 && dot_seen) record_verdict(ERR_TRAIL_DOT, open_at, span);
                    else if (span >= id_limit) record_verdict(ERR_TOO_LONG, open_at, span);
                    else if (b.last) record_verdict(ERR_OK, open_at, span);
                    else scan_ph = PH_AFTER;
                end else if (c == CH_LT || blank(c)) begin
                    record_verdict(ERR_BAD_CHAR, open_at, span);
                end else begin
                    dot_seen = (c == CH_DOT);
                    if (b.last) record_verdict(ERR_NO_CLOSE, open_at, span);
                end
            end
            PH_AFTER: begin
                if (c == CH_NUL || blank(c)) record_verdict(ERR_OK, open_at, span);
                else record_verdict(ERR_GARBAGE, open_at, span);
            end
            default: ;  // verdict already given: drop the rest of the string
        endcase

        if (b.last) begin
            scan_ph = PH_SKIP;
            scan_pos = '0;
            open_at = '0;
            span = '0;
            dot_seen = 1'b0;
        end
    endtask

    task automatic log_miss(input string what, input msgid_out_t want,
                            input msgid_out_t got);
        miss_count++;
        if (miss_count <= 10)
            $display({"%s: want ok=%0d code=%0d start=%0d len=%0d,",
                      " got ok=%0d code=%0d start=%0d len=%0d"},
                     what, want.valid_res, want.error_code, want.start_offset,
                     want.id_length, got.valid_res, got.error_code,
                     got.start_offset, got.id_length);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer bytes from beat_q, hold each until taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (beat_q.size() != 0 && !(gaps_on && $urandom_range(99) < 31)) begin
                s_valid   <= 1'b1;
                s_payload <= beat_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_rx && !(gaps_on && $urandom_range(99) < 31);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check verdicts first, then predict from the byte taken now
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        msgid_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    log_miss("unexpected verdict", '0, m_payload);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_payload.valid_res !== want.valid_res ||
                        m_payload.error_code !== want.error_code ||
                        m_payload.start_offset !== want.start_offset ||
                        m_payload.id_length !== want.id_length)
                        log_miss("verdict mismatch", want, m_payload);
                end
            end
            if (s_valid && s_ready) begin
                beats_taken++;
                scan_byte(s_payload);
            end
            if (cfg_valid && cfg_ready) id_limit = cfg_max_len;
        end
    end

    // ------------------------------------------------------------------
    // String building helpers
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [CHAR_W-1:0] c);
        str_buf.push_back(c);
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) str_buf.push_back(t[i]);
    endtask

    // Flag the final byte and hand the string to the driver
    task automatic ship();
        msgid_in_t b;
        while (str_buf.size() != 0) begin
            b.char_in = str_buf.pop_front();
            b.last = (str_buf.size() == 0);
            beat_q.push_back(b);
            beats_queued++;
        end
    endtask

    function automatic logic [CHAR_W-1:0] any_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Any byte the body accepts, with dots weighted up
    function automatic logic [CHAR_W-1:0] body_byte();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(99) < 15) return CH_DOT;
        do c = CHAR_W'($urandom_range(255));
        while (c == CH_NUL || c == CH_LT || c == CH_GT || blank(c));
        return c;
    endfunction

    // A byte that breaks the body: stray '<', blank, NUL, or an early '>'
    function automatic logic [CHAR_W-1:0] spoiler();
        case ($urandom_range(3))
            0: return CH_LT;
            1: return any_blank();
            2: return CH_NUL;
            default: return CH_GT;
        endcase
    endfunction

    // Mostly well-formed ids with random content; some broken, some noise
    task automatic random_string();
        int shape;
        int n;
        int cut;
        int tail;
        shape = $urandom_range(99);
        if (shape >= 85) begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(CHAR_W'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(2)) put_byte(any_blank());
            put_byte(CH_LT);
            n = $urandom_range(9);
            cut = (shape >= 70) ? $urandom_range(n) : -1;
            for (int k = 0; k < n; k++)
                put_byte(k == cut ? spoiler() : body_byte());
            if (cut == n) put_byte(spoiler());
            // broken strings sometimes lose the closing bracket
            if (shape < 70 || $urandom_range(1) == 1) begin
                put_byte(CH_GT);
                tail = $urandom_range(9);
                if (tail == 5 || tail == 6) begin
                    put_byte(any_blank());
                    repeat ($urandom_range(2)) put_byte(CHAR_W'($urandom_range(255)));
                end else if (tail == 7) begin
                    put_byte(body_byte());
                end else if (tail == 8) begin
                    put_byte(CH_NUL);
                end else if (tail == 9) begin
                    repeat ($urandom_range(1, 3)) put_byte(CHAR_W'($urandom_range(255)));
                end
            end
        end
        ship();
    endtask

    task automatic random_run(input int count);
        int stop_at;
        stop_at = beats_queued + count;
        while (beats_queued < stop_at) random_string();
    endtask

    // Wait for the block to go quiet: nothing queued, nothing owed, then settle
    task automatic drain();
        while (beat_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] v);
        @(posedge aclk);
        cfg_valid   <= 1'b1;
        cfg_max_len <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Starve the receiver once while the sender keeps pushing bytes
    initial begin
        while (beats_taken < 60) @(negedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_rx = 1'b0;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        while (!aresetn) @(negedge aclk);
        @(negedge aclk);

        // Reset limit of 250: strings for each verdict kind except too long
        put_text("<a@b>"); ship();
        put_byte(CH_SPACE); put_byte(CH_TAB); put_byte(CH_CR); put_byte(CH_LF);
        put_text("<x>"); ship();
        put_text("a"); ship();
        put_byte(CH_SPACE); put_byte(CH_TAB); ship();          // nothing but blanks
        put_byte(CH_NUL); put_text("z"); ship();                // NUL before '<'
        put_text("<"); ship();
        put_text("<a"); put_byte(CH_SPACE); put_text("b>"); ship();
        put_text("<a<"); ship();
        put_text("<ab"); ship();
        put_text("<a.>"); ship();
        put_text("<.>"); ship();                                // shortest dot id is fine
        put_text("<a>x"); ship();
        put_text("<a>"); put_byte(CH_SPACE); ship();
        put_text("<a>"); put_byte(CH_NUL); put_text("q"); ship();
        put_text("<a"); put_byte(CH_NUL); put_text("b>"); ship();
        put_text("<"); put_byte(8'hFF); put_byte(8'h80); put_text(">"); ship();
        random_run(120);
        drain();

        // Tight limit: length checks against body errors and garbage
        write_max_len(10'd5);
        put_text("<abcdef>x"); ship();
        put_text("<abc"); put_byte(CH_TAB); put_text("def>"); ship();
        put_text("<abc>"); ship();
        random_run(100);
        drain();

        // Zero limit: every closed id is too long unless the trailing-dot check wins
        write_max_len(10'd0);
        put_text("<>"); ship();
        put_text("<.>"); ship();
        random_run(40);
        drain();

        // Limit 3 with both sides running flat out
        write_max_len(10'd3);
        gaps_on = 1'b0;
        put_text("<>"); ship();
        put_text("<a>"); ship();
        put_text("<ab.>"); ship();
        random_run(60);
        drain();
        gaps_on = 1'b1;

        // Top limit: longer ids still pass
        write_max_len(10'd1023);
        put_text("<ab>"); ship();
        put_text("<"); repeat (30) put_text("y"); put_text(">"); ship();
        random_run(40);
        drain();

        write_max_len(LEN_W'($urandom_range(4, 40)));
        random_run(50);
        drain();

        if (miss_count == 0 && verdict_q.size() == 0) begin
            $display("message_id_validator_test: clean");
        end else begin
            $display("message_id_validator_test: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("message_id_validator_test: errors");
        $finish;
    end

endmodule
